@@ rtl/bsfr_pkg.sv @@
package bsfr_pkg;

    // Frame delimiter and escape byte on the line.
    localparam logic [7:0] FLAG_BYTE = 8'hAB;

    // Register reset values.
    localparam logic [15:0] POLY_RESET = 16'hA001;
    localparam logic [15:0] SEED_RESET = 16'hFFFF;

    // Largest number of bytes stored for one frame; later bytes are dropped.
    localparam int MAX_FRAME = 256;
    localparam int CNT_W     = $clog2(MAX_FRAME + 1);

    // Configuration register indexes.
    localparam logic REG_CRC_POLY = 1'b0;
    localparam logic REG_CRC_SEED = 1'b1;

    // Result kinds carried in the tuser kind bit.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

    // Output tdata width: 50 field bits rounded up to whole bytes.
    localparam int TDATA_W = 56;
    localparam int TUSER_W = 2;

    typedef enum logic [1:0] {
        STATUS_GOOD      = 2'd0,
        STATUS_CRC_FAIL  = 2'd1,
        STATUS_TOO_SHORT = 2'd2
    } status_t;

    // One result of the deframer, before the output register.
    typedef struct packed {
        logic        valid;
        logic        kind;
        logic [7:0]  data;
        logic        first_of_frame;
        status_t     status;
        logic [7:0]  payload_length;
        logic [15:0] frames_seen;
        logic [15:0] frames_good;
    } result_t;

endpackage

@@ rtl/byte_stuffed_frame_receiver_crc16_unit.sv @@
// A line byte is captured in the input register and its result, if any, in the output
// register, from which the master side presents it; both hold while the output stalls.
// Throughput: one line byte per cycle while m_tready is high; at most one result per byte.
// While a result waits, the input register takes at most one more byte, then s_tready drops.
// Reset: synchronous, active low on aresetn; clears the framing state and counters
// and loads crc_poly with 0xA001 and crc_seed with 0xFFFF. No clearing pass is needed.
module byte_stuffed_frame_receiver_crc16_unit
    import bsfr_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    // Input stream: one raw line byte per transaction.
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] rx_byte

    // Result stream: payload bytes and frame end reports.
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [7:0] data, [9:8] status,
                                          // [17:10] payload_length,
                                          // [33:18] frames_seen,
                                          // [49:34] frames_good, [55:50] zero
    output logic [TUSER_W-1:0] m_tuser,   // [0] kind, [1] first_of_frame

    // Configuration write port.
    input  logic               cfg_wr_en,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_wdata
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic [15:0] crc_poly_reg;
    logic [15:0] crc_seed_reg;
    logic        out_valid_reg;
    logic [TDATA_W-1:0] out_data_reg;
    logic [TUSER_W-1:0] out_user_reg;
    logic        out_free;
    logic        advance;
    result_t     res;

    // The output register can take a new result when it is empty or being drained.
    // The byte in the input register moves through the deframer whenever that is so,
    // whether or not it produces a result.
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_poly_reg <= POLY_RESET;
            crc_seed_reg <= SEED_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_CRC_POLY: crc_poly_reg <= cfg_wdata;
                REG_CRC_SEED: crc_seed_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    bsfr_deframer u_deframer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (advance),
        .rx_byte  (in_byte_reg),
        .crc_poly (crc_poly_reg),
        .crc_seed (crc_seed_reg),
        .res      (res)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= advance && res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && advance && res.valid) begin
            out_data_reg <= {6'b0, res.frames_good, res.frames_seen, res.payload_length,
                             res.status, res.data};
            out_user_reg <= {res.first_of_frame, res.kind};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

`ifndef SYNTHESIS
    a_held_byte_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_free |=> in_valid_reg && $stable(in_byte_reg))
        else $error("input byte lost while the output was stalled");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] == KIND_REPORT |-> m_tdata[9:8] != 2'd3)
        else $error("frame end report carries an undefined status");

    a_short_length: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] == KIND_REPORT && m_tdata[9:8] == STATUS_TOO_SHORT
        |-> m_tdata[17:10] == 8'd0 && m_tuser[1] == 1'b0)
        else $error("too-short report has a nonzero length");
`endif

endmodule

@@ rtl/bsfr_crc16_fold.sv @@
module bsfr_crc16_fold
    import bsfr_pkg::*;
(
    input  logic [15:0] crc_in,
    input  logic [7:0]  data_in,
    input  logic [15:0] poly,
    output logic [15:0] crc_out
);

    // Reflected CRC, one bit per step, least significant bit first.
    always_comb begin
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data_in};
        for (int i = 0; i < 8; i++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ poly;
            end else begin
                crc = crc >> 1;
            end
        end
        crc_out = crc;
    end

endmodule

@@ rtl/bsfr_deframer.sv @@
module bsfr_deframer
    import bsfr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic [7:0]  rx_byte,
    input  logic [15:0] crc_poly,
    input  logic [15:0] crc_seed,
    output result_t     res
);

    logic             in_frame_reg, in_frame_next;
    logic             flag_pending_reg, flag_pending_next;
    logic [CNT_W-1:0] stored_count_reg, stored_count_next;
    logic [7:0]       held0_reg, held0_next;
    logic [7:0]       held1_reg, held1_next;
    logic [15:0]      running_crc_reg, running_crc_next;
    logic [15:0]      seen_count_reg, seen_count_next;
    logic [15:0]      good_count_reg, good_count_next;
    logic [15:0]      crc_folded;

    bsfr_crc16_fold u_fold (
        .crc_in  (running_crc_reg),
        .data_in (held0_reg),
        .poly    (crc_poly),
        .crc_out (crc_folded)
    );

    always_comb begin
        logic [7:0]       store_byte;
        logic [CNT_W-1:0] count_base;
        in_frame_next     = in_frame_reg;
        flag_pending_next = flag_pending_reg;
        stored_count_next = stored_count_reg;
        held0_next        = held0_reg;
        held1_next        = held1_reg;
        running_crc_next  = running_crc_reg;
        seen_count_next   = seen_count_reg;
        good_count_next   = good_count_reg;
        res               = '0;
        store_byte = (in_frame_reg && flag_pending_reg) ? FLAG_BYTE : rx_byte;
        count_base = in_frame_reg ? stored_count_reg : '0;

        if (step) begin
            if (rx_byte != FLAG_BYTE) begin
                if (!in_frame_reg) begin
                    running_crc_next = crc_seed;
                end
                in_frame_next = 1'b1;
                if (count_base < CNT_W'(MAX_FRAME)) begin
                    if (count_base == CNT_W'(0)) begin
                        held0_next = store_byte;
                    end else if (count_base == CNT_W'(1)) begin
                        held1_next = store_byte;
                    end else begin
                        // The oldest held byte is now known to be payload.
                        res.valid          = 1'b1;
                        res.kind           = KIND_PAYLOAD;
                        res.data           = held0_reg;
                        res.first_of_frame = (count_base == CNT_W'(2));
                        running_crc_next   = crc_folded;
                        held0_next         = held1_reg;
                        held1_next         = store_byte;
                    end
                    stored_count_next = count_base + CNT_W'(1);
                end else begin
                    stored_count_next = count_base;
                end
                flag_pending_next = 1'b0;
            end else begin
                if (flag_pending_reg && in_frame_reg) begin
                    res.valid = 1'b1;
                    res.kind  = KIND_REPORT;
                    if (stored_count_reg > CNT_W'(2)) begin
                        seen_count_next    = seen_count_reg + 16'd1;
                        res.payload_length = 8'(stored_count_reg - CNT_W'(2));
                        if ({held1_reg, held0_reg} == running_crc_reg) begin
                            good_count_next = good_count_reg + 16'd1;
                            res.status      = STATUS_GOOD;
                        end else begin
                            res.status = STATUS_CRC_FAIL;
                        end
                    end else begin
                        res.status = STATUS_TOO_SHORT;
                    end
                    res.frames_seen   = seen_count_next;
                    res.frames_good   = good_count_next;
                    stored_count_next = '0;
                end
                if (flag_pending_reg) begin
                    in_frame_next = 1'b0;
                end
                flag_pending_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg     <= 1'b0;
            flag_pending_reg <= 1'b0;
            stored_count_reg <= '0;
            running_crc_reg  <= SEED_RESET;
            seen_count_reg   <= '0;
            good_count_reg   <= '0;
        end else begin
            in_frame_reg     <= in_frame_next;
            flag_pending_reg <= flag_pending_next;
            stored_count_reg <= stored_count_next;
            running_crc_reg  <= running_crc_next;
            seen_count_reg   <= seen_count_next;
            good_count_reg   <= good_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        held0_reg <= held0_next;
        held1_reg <= held1_next;
    end

`ifndef SYNTHESIS
    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        stored_count_reg <= CNT_W'(MAX_FRAME))
        else $error("stored byte count exceeds the frame limit");

    a_idle_count_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_frame_reg |-> stored_count_reg == '0)
        else $error("byte count not cleared outside a frame");

    a_report_closes_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid && res.kind == KIND_REPORT |=> !in_frame_reg && stored_count_reg == '0)
        else $error("frame still open after its end report");
`endif

endmodule

@@ tb/byte_stuffed_frame_receiver_crc16_unit_tb.sv @@
`timescale 1ns / 100ps

module byte_stuffed_frame_receiver_crc16_unit_tb;
    import bsfr_pkg::*;

    typedef logic [7:0] line_bytes_t[$];

    // Tracks the deframer state from the accepted line bytes and checks every
    // result transaction against the oldest expected output.
    class frame_scoreboard;
        logic [15:0] poly;
        logic [15:0] seed;
        bit          in_frame;
        bit          flag_pending;
        int          stored_count;
        logic [7:0]  held [2];
        logic [15:0] running_crc;
        logic [15:0] seen_count;
        logic [15:0] good_count;
        result_t     due_outputs[$];
        int          errors;
        int          payload_checked;
        int          reports_checked;

        function new();
            poly            = POLY_RESET;
            seed            = SEED_RESET;
            in_frame        = 0;
            flag_pending    = 0;
            stored_count    = 0;
            held[0]         = '0;
            held[1]         = '0;
            running_crc     = SEED_RESET;
            seen_count      = '0;
            good_count      = '0;
            errors          = 0;
            payload_checked = 0;
            reports_checked = 0;
        endfunction

        static function logic [15:0] fold_crc(logic [15:0] crc, logic [7:0] b,
                                              logic [15:0] p);
            logic [15:0] c;
            c = crc ^ {8'h00, b};
            for (int i = 0; i < 8; i++) begin
                c = c[0] ? ((c >> 1) ^ p) : (c >> 1);
            end
            return c;
        endfunction

        function void set_reg(logic idx, logic [15:0] value);
            if (idx == REG_CRC_POLY) begin
                poly = value;
            end else begin
                seed = value;
            end
        endfunction

        // The two newest stored bytes are held back as the CRC candidate.
        function void store_byte(logic [7:0] b);
            result_t r;
            if (stored_count >= MAX_FRAME) return;
            if (stored_count == 0) begin
                held[0] = b;
            end else if (stored_count == 1) begin
                held[1] = b;
            end else begin
                r                = '0;
                r.valid          = 1'b1;
                r.kind           = KIND_PAYLOAD;
                r.data           = held[0];
                r.first_of_frame = (stored_count == 2);
                r.status         = STATUS_GOOD;
                due_outputs.push_back(r);
                running_crc = fold_crc(running_crc, held[0], poly);
                held[0]     = held[1];
                held[1]     = b;
            end
            stored_count++;
        endfunction

        function void close_frame();
            result_t r;
            r       = '0;
            r.valid = 1'b1;
            r.kind  = KIND_REPORT;
            if (stored_count > 2) begin
                seen_count++;
                r.payload_length = 8'(stored_count - 2);
                if ({held[1], held[0]} == running_crc) begin
                    good_count++;
                    r.status = STATUS_GOOD;
                end else begin
                    r.status = STATUS_CRC_FAIL;
                end
            end else begin
                r.status = STATUS_TOO_SHORT;
            end
            r.frames_seen = seen_count;
            r.frames_good = good_count;
            due_outputs.push_back(r);
            stored_count = 0;
        endfunction

        function void note_line_byte(logic [7:0] b);
            if (b != FLAG_BYTE) begin
                if (in_frame) begin
                    store_byte(flag_pending ? FLAG_BYTE : b);
                end else begin
                    in_frame     = 1;
                    stored_count = 0;
                    running_crc  = seed;
                    store_byte(b);
                end
                flag_pending = 0;
            end else begin
                if (flag_pending) begin
                    if (in_frame) close_frame();
                    in_frame = 0;
                end
                flag_pending = 1;
            end
        endfunction

        function void compare_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(logic [TDATA_W-1:0] td, logic [TUSER_W-1:0] tu);
            result_t e;
            if (due_outputs.size() == 0) begin
                $error("unexpected result transaction: tdata 0x%0h, tuser 0x%0h", td, tu);
                errors++;
                return;
            end
            e = due_outputs.pop_front();
            if (e.kind == KIND_PAYLOAD) begin
                payload_checked++;
            end else begin
                reports_checked++;
            end
            compare_field("kind", e.kind, tu[0]);
            compare_field("first_of_frame", e.first_of_frame, tu[1]);
            compare_field("data", e.data, td[7:0]);
            compare_field("status", e.status, td[9:8]);
            compare_field("payload_length", e.payload_length, td[17:10]);
            compare_field("frames_seen", e.frames_seen, td[33:18]);
            compare_field("frames_good", e.frames_good, td[49:34]);
        endfunction

        function int pending();
            return due_outputs.size();
        endfunction
    endclass

    // A generous bound on the length of the run.
    localparam int CYCLE_LIMIT = 200_000;

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;
    logic [TUSER_W-1:0] m_tuser;
    logic               cfg_wr_en;
    logic               cfg_index;
    logic [15:0]        cfg_wdata;

    frame_scoreboard sb = new();

    int cycle_count   = 0;
    int idle_pct      = 20;
    int bytes_sent    = 0;
    int settings_used = 1;

    byte_stuffed_frame_receiver_crc16_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Every input is known from time zero; inputs only change at the falling edge.
    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_CRC_POLY;
        cfg_wdata = '0;
    end

    // The receiver stalls at the same rate as the sender idles. Setting idle_pct
    // to zero gives the long stretch in which neither side ever holds off.
    always @(negedge aclk) begin
        m_tready = ($urandom_range(99, 0) >= idle_pct);
    end

    // Outputs are sampled at the rising edge, before the block updates them, so a
    // result transaction is seen exactly as the block presented it.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata, m_tuser);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk);
        $display("Timeout after %0d cycles with %0d results outstanding.",
                 cycle_count, sb.pending());
        $display("byte_stuffed_frame_receiver_crc16_unit_tb: FAIL");
        $finish;
    end

    // Offers one line byte and holds it until the input transaction completes.
    // Called at a falling edge and returns at a falling edge with tvalid still
    // high, so back-to-back transactions need no toggling of tvalid.
    task automatic send_byte(logic [7:0] b, bit counted);
        while ($urandom_range(99, 0) < idle_pct) begin
            s_tvalid = 1'b0;
            s_tdata  = 8'($urandom);
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_line_byte(b);
        if (counted) bytes_sent++;
        @(negedge aclk);
    endtask

    // Flags between frames are ignored by the block and are not counted.
    task automatic send_flags(int n);
        repeat (n) send_byte(FLAG_BYTE, 1'b0);
    endtask

    // Sends a complete frame: the body, its little-endian CRC (optionally
    // corrupted), any tail bytes, and the closing flag pair. A flag value inside
    // the frame goes out as a flag followed by an arbitrary non-flag byte.
    task automatic send_frame(line_bytes_t body, bit corrupt, int tail);
        line_bytes_t stored;
        logic [15:0] crc;
        logic [7:0]  esc;
        crc = sb.seed;
        foreach (body[i]) crc = frame_scoreboard::fold_crc(crc, body[i], sb.poly);
        if (corrupt) crc ^= 16'($urandom_range(16'hFFFF, 1));
        stored = body;
        stored.push_back(crc[7:0]);
        stored.push_back(crc[15:8]);
        repeat (tail) stored.push_back(8'($urandom));
        foreach (stored[i]) begin
            if (stored[i] == FLAG_BYTE) begin
                esc = 8'($urandom);
                if (esc == FLAG_BYTE) esc = 8'h00;
                send_byte(FLAG_BYTE, 1'b1);
                send_byte(esc, 1'b1);
            end else begin
                send_byte(stored[i], 1'b1);
            end
        end
        send_byte(FLAG_BYTE, 1'b1);
        send_byte(FLAG_BYTE, 1'b1);
    endtask

    // Random frame content with flag values made common enough to exercise the
    // escape path. The first byte is never a flag, since it opens the frame.
    function automatic line_bytes_t random_body(int len);
        line_bytes_t q;
        logic [7:0]  b;
        for (int i = 0; i < len; i++) begin
            b = ($urandom_range(9, 0) == 0) ? FLAG_BYTE : 8'($urandom);
            if (i == 0 && b == FLAG_BYTE) b = 8'h5A;
            q.push_back(b);
        end
        return q;
    endfunction

    // Stops offering input until every expected result has arrived, then lets
    // the pipeline settle so that a register write lands while the block is idle.
    task automatic drain_outputs();
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] value);
        cfg_index = idx;
        cfg_wdata = value;
        cfg_wr_en = 1'b1;
        @(posedge aclk);
        sb.set_reg(idx, value);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // Mostly well-formed frames with random content and size, plus broken
    // frames, raw noise rich in flags, and runs of extra flags.
    task automatic run_random(int target);
        int          pick;
        int          len;
        int          tail;
        line_bytes_t body;
        while (bytes_sent < target) begin
            pick = $urandom_range(99, 0);
            if (pick < 70) begin
                tail = 0;
                if ($urandom_range(99, 0) < 3) begin
                    // Long frames around the storage limit; some are exactly full
                    // with a valid CRC followed by bytes that get dropped.
                    if ($urandom_range(2, 0) == 0) begin
                        len  = MAX_FRAME - 2;
                        tail = $urandom_range(5, 1);
                    end else begin
                        len = $urandom_range(MAX_FRAME + 14, MAX_FRAME - 16);
                    end
                end else begin
                    len = $urandom_range(10, 1);
                end
                body = random_body(len);
                send_frame(body, $urandom_range(99, 0) < 20, tail);
            end else if (pick < 80) begin
                // A frame cut short: random bytes, maybe a dangling escape, then end.
                body = random_body($urandom_range(5, 1));
                foreach (body[i]) send_byte(body[i], 1'b1);
                if ($urandom_range(1, 0)) send_byte(FLAG_BYTE, 1'b1);
                send_byte(FLAG_BYTE, 1'b1);
                send_byte(FLAG_BYTE, 1'b1);
            end else if (pick < 90) begin
                repeat ($urandom_range(8, 1)) begin
                    send_byte(($urandom_range(9, 0) < 3) ? FLAG_BYTE : 8'($urandom), 1'b1);
                end
            end else begin
                send_flags($urandom_range(4, 1));
            end
        end
    endtask

    initial begin
        line_bytes_t body;

        // Reset is held from time zero and released at a falling edge.
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed part. A lone flag outside a frame is ignored, and the byte
        // after it opens a one-byte frame that ends as too short.
        send_byte(FLAG_BYTE, 1'b1);
        send_byte(8'h12, 1'b1);
        send_byte(FLAG_BYTE, 1'b1);
        send_byte(FLAG_BYTE, 1'b1);
        // A repeated flag after a frame end does nothing.
        send_flags(1);
        // A good frame with an all-ones byte and an escaped flag value.
        body = '{8'hFF, FLAG_BYTE};
        send_frame(body, 1'b0, 0);
        // A frame with the bytes 0x00 and 0x01 and a wrong CRC.
        body = '{8'h00, 8'h01};
        send_frame(body, 1'b1, 0);
        // A two-byte frame, also too short.
        send_byte(8'h34, 1'b1);
        send_byte(8'h56, 1'b1);
        send_byte(FLAG_BYTE, 1'b1);
        send_byte(FLAG_BYTE, 1'b1);

        // Random part under the reset register values.
        run_random(400);

        // Lowest register values.
        drain_outputs();
        write_reg(REG_CRC_POLY, 16'h0000);
        write_reg(REG_CRC_SEED, 16'h0000);
        settings_used++;
        run_random(700);

        // Highest register values.
        drain_outputs();
        write_reg(REG_CRC_POLY, 16'hFFFF);
        write_reg(REG_CRC_SEED, 16'hFFFF);
        settings_used++;
        run_random(1000);

        // Open a frame, let the results drain, and change both registers while
        // the frame is still open: the new polynomial applies to the next byte
        // folded in, the new seed only to the next frame.
        body = random_body(3);
        foreach (body[i]) send_byte(body[i], 1'b1);
        drain_outputs();
        write_reg(REG_CRC_POLY, 16'($urandom));
        write_reg(REG_CRC_SEED, 16'($urandom));
        settings_used++;
        run_random(1300);

        // Back to the reset register values, then a long stretch with no idling
        // on either side.
        drain_outputs();
        write_reg(REG_CRC_POLY, POLY_RESET);
        write_reg(REG_CRC_SEED, SEED_RESET);
        settings_used++;
        idle_pct = 0;
        run_random(1600);
        idle_pct = 20;

        // Wait for every expected result, then keep watching the output for strays.
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Covered %0d line bytes over %0d register settings, ending with a",
                 bytes_sent, settings_used);
        $display("stretch free of stalls; %0d payload bytes and %0d reports checked.",
                 sb.payload_checked, sb.reports_checked);
        if (sb.errors == 0) begin
            $display("byte_stuffed_frame_receiver_crc16_unit_tb: PASS");
        end else begin
            $display("byte_stuffed_frame_receiver_crc16_unit_tb: FAIL");
        end
        $finish;
    end

endmodule
